>>> hw/rtl/modbus_rtu_read_register_slave_defines.svh
// Assertion macros for the Modbus RTU read-register slave.
// Used by the top level only; expects signals named clock and reset.
`ifndef MODBUS_RTU_READ_REGISTER_SLAVE_DEFINES_SVH
`define MODBUS_RTU_READ_REGISTER_SLAVE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MRR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define MRR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/mrr_pkg.sv
// Shared types and constants for the Modbus RTU read-register slave.
// No dependencies.
`timescale 1ns / 1ps

package mrr_pkg;

   localparam int REQ_FRAME_BYTES = 8;

   localparam logic [1:0] REQ_BYTE = 2'd0;
   localparam logic [1:0] REQ_POLL = 2'd1;
   localparam logic [1:0] REQ_WORD = 2'd2;

   localparam logic [7:0] FC_READ_HOLD  = 8'h03;
   localparam logic [7:0] FC_READ_INPUT = 8'h04;
   localparam logic [7:0] EXC_FLAG      = 8'h80;
   localparam logic [7:0] EXC_FUNC      = 8'h01;
   localparam logic [7:0] EXC_ADDR      = 8'h02;
   localparam logic [7:0] EXC_VALUE     = 8'h03;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic CSR_SLAVE_ADDR = 1'b0;
   localparam logic CSR_GAP_TICKS  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_FCRC_LOAD,
      ST_FCRC_BIT,
      ST_FCRC_CMP,
      ST_TX_BYTE,
      ST_TX_BIT
   } state_type;

   typedef struct packed {
      logic byte_in;
      logic word_wr;
      logic poll;
      logic crc_init;
      logic crc_xor_frame;
      logic crc_shift;
      logic idx_inc;
      logic decide;
      logic tx_load;
   } cmd_type;

   typedef struct packed {
      logic waiting;
      logic addr_ok;
      logic bit_last;
      logic fidx_last;
      logic crc_ok;
      logic out_free;
      logic tx_is_body;
      logic tx_is_last;
   } sts_type;

endpackage

>>> hw/rtl/mrr_ctrl.sv
// Sequencer for the read-register slave: frame check and reply emission.
// Depends on mrr_pkg.
`timescale 1ns / 1ps

module mrr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic [1:0]        req_type,
   input  logic              req_overflow,
   input  mrr_pkg::sts_type  sts,
   output logic              req_tready,
   output mrr_pkg::cmd_type  cmd,
   output mrr_pkg::state_type state
);

   mrr_pkg::state_type state_ff, state_in;
   logic accept;

   assign req_tready = (state_ff == mrr_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign state      = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mrr_pkg::ST_IDLE: begin
            if (accept && req_type == mrr_pkg::REQ_POLL && !req_overflow && sts.waiting)
               state_in = mrr_pkg::ST_ADDR;
         end
         mrr_pkg::ST_ADDR: begin
            state_in = sts.addr_ok ? mrr_pkg::ST_FCRC_LOAD : mrr_pkg::ST_IDLE;
         end
         mrr_pkg::ST_FCRC_LOAD: state_in = mrr_pkg::ST_FCRC_BIT;
         mrr_pkg::ST_FCRC_BIT: begin
            if (sts.bit_last)
               state_in = sts.fidx_last ? mrr_pkg::ST_FCRC_CMP : mrr_pkg::ST_FCRC_LOAD;
         end
         mrr_pkg::ST_FCRC_CMP: begin
            state_in = sts.crc_ok ? mrr_pkg::ST_TX_BYTE : mrr_pkg::ST_IDLE;
         end
         mrr_pkg::ST_TX_BYTE: begin
            if (sts.out_free) begin
               if (sts.tx_is_last)
                  state_in = mrr_pkg::ST_IDLE;
               else if (sts.tx_is_body)
                  state_in = mrr_pkg::ST_TX_BIT;
            end
         end
         mrr_pkg::ST_TX_BIT: begin
            if (sts.bit_last)
               state_in = mrr_pkg::ST_TX_BYTE;
         end
         default: state_in = mrr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         mrr_pkg::ST_IDLE: begin
            cmd.byte_in = accept && req_type == mrr_pkg::REQ_BYTE;
            cmd.poll    = accept && req_type == mrr_pkg::REQ_POLL;
            cmd.word_wr = accept && req_type == mrr_pkg::REQ_WORD;
         end
         mrr_pkg::ST_ADDR:      cmd.crc_init = 1'b1;
         mrr_pkg::ST_FCRC_LOAD: cmd.crc_xor_frame = 1'b1;
         mrr_pkg::ST_FCRC_BIT: begin
            cmd.crc_shift = 1'b1;
            cmd.idx_inc   = sts.bit_last;
         end
         mrr_pkg::ST_FCRC_CMP:  cmd.decide = 1'b1;
         mrr_pkg::ST_TX_BYTE:   cmd.tx_load = sts.out_free;
         mrr_pkg::ST_TX_BIT:    cmd.crc_shift = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

>>> hw/rtl/mrr_dp.sv
// Datapath: framing, data word store, bit-serial CRC-16 and reply register.
// Depends on mrr_pkg; commanded by mrr_ctrl.
`timescale 1ns / 1ps

module mrr_dp #(
   parameter int DATA_WORDS = 8,
   parameter int MAX_READ   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata,
   input  logic [7:0]       rx_byte,
   input  logic [15:0]      rx_tick,
   input  logic             rx_overflow,
   input  logic [2:0]       word_index,
   input  logic [15:0]      word_value,
   input  mrr_pkg::cmd_type cmd,
   input  logic             rsp_tready,
   output mrr_pkg::sts_type sts,
   output logic             rsp_tvalid,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);

   localparam int AW    = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
   localparam int DEPTH = 1 << AW;

   logic [7:0]  slave_addr_ff;
   logic [15:0] gap_ff;

   logic [7:0]  frame_ff [mrr_pkg::REQ_FRAME_BYTES];
   logic [2:0]  fill_ff, fill_in;
   logic [15:0] last_tick_ff;
   logic        waiting_ff, waiting_in;
   logic [15:0] elapsed;

   logic [15:0]      mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [15:0]      rd_data_ff;
   logic             rd_valid_ff;
   logic [AW-1:0]    rd_addr;
   logic [15:0]      rd_sum;
   logic [7:0]       wi;
   logic [6:0]       widx;

   logic [15:0] crc_ff, crc_step;
   logic [2:0]  bit_ff;
   logic [2:0]  idx_ff;
   logic [7:0]  k_ff;
   logic [7:0]  body_ff;
   logic        exc_ff;
   logic [7:0]  code_ff;

   logic [7:0]  fc;
   logic [15:0] start_w, count_w;
   logic [16:0] range_end;
   logic [7:0]  body_byte, tx_byte, word_byte;
   logic        out_free;

   logic        valid_ff;
   logic [7:0]  tdata_ff;
   logic        tlast_ff, tuser_ff;

   assign fc        = frame_ff[1];
   assign start_w   = {frame_ff[2], frame_ff[3]};
   assign count_w   = {frame_ff[4], frame_ff[5]};
   assign range_end = {1'b0, start_w} + {1'b0, count_w};
   assign elapsed   = rx_tick - last_tick_ff;
   assign crc_step  = crc_ff[0] ? ((crc_ff >> 1) ^ mrr_pkg::CRC_POLY) : (crc_ff >> 1);
   assign out_free  = !valid_ff || rsp_tready;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= 8'd1;
         gap_ff        <= 16'd15;
      end else if (csr_we) begin
         case (csr_index)
            mrr_pkg::CSR_SLAVE_ADDR: slave_addr_ff <= csr_wdata[7:0];
            mrr_pkg::CSR_GAP_TICKS:  gap_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // framing
   always_comb begin
      fill_in    = fill_ff;
      waiting_in = waiting_ff;
      if (cmd.byte_in && !waiting_ff) begin
         fill_in = (elapsed >= gap_ff) ? 3'd0 : fill_ff;
         if (fill_in == 3'(mrr_pkg::REQ_FRAME_BYTES - 1)) begin
            waiting_in = 1'b1;
            fill_in    = 3'd0;
         end else begin
            fill_in = fill_in + 3'd1;
         end
      end
      if (cmd.poll) begin
         waiting_in = 1'b0;
         if (rx_overflow)
            fill_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         last_tick_ff <= '0;
         waiting_ff   <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         waiting_ff <= waiting_in;
         if (cmd.byte_in)
            last_tick_ff <= rx_tick;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_in && !waiting_ff)
         frame_ff[(elapsed >= gap_ff) ? 3'd0 : fill_ff] <= rx_byte;
   end

   // data word store; invalid entries read as zero
   assign widx    = {4'd0, word_index};
   assign wi      = (k_ff - 8'd3) >> 1;
   assign rd_sum  = start_w + {8'd0, wi};
   assign rd_addr = rd_sum[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.word_wr && widx < 7'(DATA_WORDS))
         mem[widx[AW-1:0]] <= word_value;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.word_wr && widx < 7'(DATA_WORDS))
            vld_ff[widx[AW-1:0]] <= 1'b1;
         rd_valid_ff <= vld_ff[rd_addr];
      end
   end

   // crc and sequencing counters
   always_ff @(posedge clock) begin
      if (cmd.crc_init) begin
         crc_ff <= mrr_pkg::CRC_INIT;
         idx_ff <= '0;
      end
      if (cmd.crc_xor_frame) begin
         crc_ff <= crc_ff ^ {8'd0, frame_ff[idx_ff]};
         bit_ff <= '0;
      end
      if (cmd.crc_shift) begin
         crc_ff <= crc_step;
         bit_ff <= bit_ff + 3'd1;
      end
      if (cmd.idx_inc)
         idx_ff <= idx_ff + 3'd1;
      if (cmd.decide) begin
         crc_ff <= mrr_pkg::CRC_INIT;
         k_ff   <= '0;
         if (fc != mrr_pkg::FC_READ_HOLD && fc != mrr_pkg::FC_READ_INPUT) begin
            exc_ff  <= 1'b1;
            code_ff <= mrr_pkg::EXC_FUNC;
         end else if (count_w == 16'd0 || count_w > 16'(MAX_READ)) begin
            exc_ff  <= 1'b1;
            code_ff <= mrr_pkg::EXC_VALUE;
         end else if (range_end > 17'(DATA_WORDS)) begin
            exc_ff  <= 1'b1;
            code_ff <= mrr_pkg::EXC_ADDR;
         end else begin
            exc_ff  <= 1'b0;
            code_ff <= {count_w[6:0], 1'b0};
         end
         body_ff <= 8'd3;
         if (fc == mrr_pkg::FC_READ_HOLD || fc == mrr_pkg::FC_READ_INPUT)
            if (count_w != 16'd0 && count_w <= 16'(MAX_READ) &&
                range_end <= 17'(DATA_WORDS))
               body_ff <= 8'd3 + {count_w[6:0], 1'b0};
      end
      if (cmd.tx_load) begin
         k_ff <= k_ff + 8'd1;
         if (k_ff < body_ff) begin
            crc_ff <= crc_ff ^ {8'd0, body_byte};
            bit_ff <= '0;
         end
      end
   end

   // reply byte selection
   always_comb begin
      word_byte = k_ff[0] ? (rd_valid_ff ? rd_data_ff[15:8] : 8'd0)
                          : (rd_valid_ff ? rd_data_ff[7:0]  : 8'd0);
      case (k_ff)
         8'd0:    body_byte = slave_addr_ff;
         8'd1:    body_byte = exc_ff ? (fc | mrr_pkg::EXC_FLAG) : fc;
         8'd2:    body_byte = code_ff;
         default: body_byte = word_byte;
      endcase
      if (k_ff < body_ff)
         tx_byte = body_byte;
      else if (k_ff == body_ff)
         tx_byte = crc_ff[7:0];
      else
         tx_byte = crc_ff[15:8];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.tx_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tx_load) begin
         tdata_ff <= tx_byte;
         tlast_ff <= (k_ff == body_ff + 8'd1);
         tuser_ff <= exc_ff;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = tdata_ff;
   assign rsp_tlast  = tlast_ff;
   assign rsp_tuser  = tuser_ff;

   assign sts.waiting    = waiting_ff;
   assign sts.addr_ok    = slave_addr_ff != 8'd0 && frame_ff[0] == slave_addr_ff;
   assign sts.bit_last   = bit_ff == 3'd7;
   assign sts.fidx_last  = idx_ff == 3'(mrr_pkg::REQ_FRAME_BYTES - 3);
   assign sts.crc_ok     = crc_ff == {frame_ff[mrr_pkg::REQ_FRAME_BYTES - 1],
                                      frame_ff[mrr_pkg::REQ_FRAME_BYTES - 2]};
   assign sts.out_free   = out_free;
   assign sts.tx_is_body = k_ff < body_ff;
   assign sts.tx_is_last = k_ff == body_ff + 8'd1;

endmodule

>>> hw/rtl/modbus_rtu_read_register_slave.sv
// Modbus RTU read-register slave: top level joining controller and datapath.
// Depends on mrr_pkg, mrr_ctrl, mrr_dp and the assertion macro header.
//
// Usage:
//   req_* carries one request per handshake; tuser selects the kind (received
//   byte, poll, data word write). rsp_* returns reply bytes, tlast on the
//   final CRC byte, tuser set on every byte of an exception reply.
//   csr_* writes slave address (index 0) or gap ticks (index 1).
// Sequence:
//   A poll that finds a frame checks the address and runs the bit-serial
//   CRC over six bytes. Each reply body byte then passes bit by bit through
//   the same CRC unit; the two CRC bytes are loaded without a CRC pass.
//   A full reply holds 21 bytes with MAX_READ at 8. One request is worked
//   at a time; req_tready is high whenever the sequencer is idle, also
//   while the last reply byte still waits in the output register.
// Reset clears framing state and data word valid bits, presets configuration.
// A stalled receiver holds the current reply byte and the sequencer waits.
`timescale 1ns / 1ps
`include "modbus_rtu_read_register_slave_defines.svh"

module modbus_rtu_read_register_slave #(
   parameter int DATA_WORDS = 8,
   parameter int MAX_READ   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rx_byte[7:0], rx_tick[23:8], rx_overflow[24], word_index[27:25],
   // word_value[43:28], zero fill [47:44]
   input  logic [47:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tx_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // reply_is_exception[0]
   output logic        rsp_tuser
);

   mrr_pkg::cmd_type   cmd;
   mrr_pkg::sts_type   sts;
   mrr_pkg::state_type state;
   logic               poll_fire;
   logic               byte_fire;

   assign poll_fire = req_tvalid && req_tready && req_tuser == mrr_pkg::REQ_POLL;
   assign byte_fire = req_tvalid && req_tready && req_tuser == mrr_pkg::REQ_BYTE;

   mrr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_type     (req_tuser),
      .req_overflow (req_tdata[24]),
      .sts          (sts),
      .req_tready   (req_tready),
      .cmd          (cmd),
      .state        (state)
   );

   mrr_dp #(
      .DATA_WORDS (DATA_WORDS),
      .MAX_READ   (MAX_READ)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rx_byte     (req_tdata[7:0]),
      .rx_tick     (req_tdata[23:8]),
      .rx_overflow (req_tdata[24]),
      .word_index  (req_tdata[27:25]),
      .word_value  (req_tdata[43:28]),
      .cmd         (cmd),
      .rsp_tready  (rsp_tready),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   // a poll always consumes the waiting frame
   `MRR_ASSERT_NEXT(a_poll_clears, poll_fire, !sts.waiting)
   // bytes arriving while a frame waits are dropped
   `MRR_ASSERT_NEXT(a_byte_drop, byte_fire && sts.waiting, sts.waiting)
   // a reply byte is loaded only into a free output register
   `MRR_ASSERT_SAME(a_load_free, cmd.tx_load, !rsp_tvalid || rsp_tready)
   // no request is taken while a frame is being handled
   `MRR_ASSERT_SAME(a_busy_stall, state != mrr_pkg::ST_IDLE, !req_tready)

endmodule
